[hdl/bdq_pkg.sv]
// ============================================================================
// bdq_pkg
// Shared types, field widths and codes of the bounded deque.
// ============================================================================
`default_nettype none

package bdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int OP_W      = 3;
  localparam int WORD_W    = 32;
  localparam int STATUS_W  = 2;

  typedef logic [OP_W-1:0]            op_t;
  typedef logic signed [WORD_W-1:0]   word_t;
  typedef logic [STATUS_W-1:0]        status_t;

  // operation codes
  localparam op_t OP_INS_FRONT = 3'd0;
  localparam op_t OP_INS_BACK  = 3'd1;
  localparam op_t OP_DEL_FRONT = 3'd2;
  localparam op_t OP_DEL_BACK  = 3'd3;
  localparam op_t OP_DEL_VALUE = 3'd4;
  localparam op_t OP_READ_ALL  = 3'd5;

  // result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

endpackage

`default_nettype wire

[hdl/bdq_in_if.sv]
// ============================================================================
// bdq_in_if
// Request channel of the deque: one operation and its operand per item.
// ============================================================================
`default_nettype none

interface bdq_in_if
  import bdq_pkg::*;
();
  logic  valid;
  logic  ready;
  op_t   operation;
  word_t value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

[hdl/bdq_out_if.sv]
// ============================================================================
// bdq_out_if
// Result channel of the deque: status, data word and last marker per item.
// ============================================================================
`default_nettype none

interface bdq_out_if
  import bdq_pkg::*;
();
  logic    valid;
  logic    ready;
  status_t status;
  word_t   data;
  logic    last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

`default_nettype wire

[hdl/bounded_deque_with_value_delete.sv]
// Insert and delete at front/back pass through S_EXEC and S_EMIT after acceptance; S_EMIT
// registers the result once the output is free. Delete by value scans and then closes the
// gap, each at one entry per cycle; read-out emits one per cycle while the output is free.
// One item is worked at a time; the single RAM read port sets the one-entry-per-cycle pace.
// Reset clears head index, entry count, sequencer and output valid; stored words stay
// undefined until written, and no clearing pass is needed.
// ============================================================================
// bounded_deque_with_value_delete
// Bounded ring deque of signed words with front/back insert and delete,
// delete by value with gap closing, and in-order read-out.
// ============================================================================
`default_nettype none

module bounded_deque_with_value_delete
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bdq_in_if.sink     in_ch,
  bdq_out_if.source  out_ch
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [PTR_W-1:0] SLOT_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_EMIT  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_RDOUT = 3'd5;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] s);
    wrap_inc = (s == SLOT_LAST) ? '0 : s + PTR_W'(1);
  endfunction

  // control state
  logic [2:0]       state_r,     state_nxt;
  logic [PTR_W-1:0] head_r,      head_nxt;
  logic [CNT_W-1:0] count_r,     count_nxt;
  logic             out_valid_r, out_valid_nxt;

  // working registers
  op_t              op_r,        op_nxt;
  word_t            val_r,       val_nxt;
  logic [CNT_W-1:0] idx_r,       idx_nxt;
  logic [PTR_W-1:0] rd_slot_r,   rd_slot_nxt;
  logic [PTR_W-1:0] wr_slot_r,   wr_slot_nxt;
  status_t          pend_status_r, pend_status_nxt;
  word_t            pend_data_r,   pend_data_nxt;
  logic             pend_ram_r,    pend_ram_nxt;
  status_t          out_status_r,  out_status_nxt;
  word_t            out_data_r,    out_data_nxt;
  logic             out_last_r,    out_last_nxt;

  // RAM port
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  word_t            ram_wdata;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  word_t            ram_rdata;

  // shared ring address unit
  logic [CNT_W-1:0] ring_off;
  logic [SUM_W-1:0] ring_sum;
  logic [PTR_W-1:0] ring_slot;
  logic [PTR_W-1:0] head_dec;
  logic [PTR_W-1:0] slot_inc;
  logic [CNT_W-1:0] idx_plus;
  logic             is_full;
  logic             is_empty;
  logic             out_free;
  logic             accept;

  assign ring_off  = (op_r == OP_INS_BACK) ? count_r : count_r - CNT_W'(1);
  assign ring_sum  = SUM_W'(head_r) + SUM_W'(ring_off);
  assign ring_slot = (ring_sum >= SUM_W'(DEPTH)) ? PTR_W'(ring_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(ring_sum);
  assign head_dec  = (head_r == '0) ? SLOT_LAST : head_r - PTR_W'(1);
  assign slot_inc  = wrap_inc(rd_slot_r);
  assign idx_plus  = idx_r + CNT_W'(1);
  assign is_full   = (count_r == CNT_FULL);
  assign is_empty  = (count_r == '0);
  assign out_free  = !out_valid_r || out_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.data   = out_data_r;
  assign out_ch.last   = out_last_r;

  bdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    op_nxt          = op_r;
    val_nxt         = val_r;
    idx_nxt         = idx_r;
    rd_slot_nxt     = rd_slot_r;
    wr_slot_nxt     = wr_slot_r;
    pend_status_nxt = pend_status_r;
    pend_data_nxt   = pend_data_r;
    pend_ram_nxt    = pend_ram_r;
    out_status_nxt  = out_status_r;
    out_data_nxt    = out_data_r;
    out_last_nxt    = out_last_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;

    ram_we    = 1'b0;
    ram_waddr = wr_slot_r;
    ram_wdata = val_r;
    ram_re    = 1'b0;
    ram_raddr = slot_inc;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_ch.operation;
          val_nxt   = in_ch.value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        pend_data_nxt = '0;
        pend_ram_nxt  = 1'b0;
        state_nxt     = S_EMIT;
        case (op_r)
          OP_INS_FRONT, OP_INS_BACK: begin
            if (is_full) begin
              pend_status_nxt = ST_FULL;
            end else begin
              ram_we = 1'b1;
              if (op_r == OP_INS_FRONT) begin
                ram_waddr = head_dec;
                head_nxt  = head_dec;
              end else begin
                ram_waddr = ring_slot;
              end
              count_nxt       = count_r + CNT_W'(1);
              pend_status_nxt = ST_OK;
            end
          end
          OP_DEL_FRONT, OP_DEL_BACK: begin
            if (is_empty) begin
              pend_status_nxt = ST_EMPTY;
            end else begin
              ram_re = 1'b1;
              if (op_r == OP_DEL_FRONT) begin
                ram_raddr = head_r;
                head_nxt  = wrap_inc(head_r);
              end else begin
                ram_raddr = ring_slot;
              end
              count_nxt       = count_r - CNT_W'(1);
              pend_status_nxt = ST_OK;
              pend_ram_nxt    = 1'b1;
            end
          end
          OP_DEL_VALUE, OP_READ_ALL: begin
            if (is_empty) begin
              pend_status_nxt = ST_EMPTY;
            end else begin
              ram_re      = 1'b1;
              ram_raddr   = head_r;
              rd_slot_nxt = head_r;
              idx_nxt     = '0;
              state_nxt   = (op_r == OP_DEL_VALUE) ? S_SCAN : S_RDOUT;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        // ram_rdata holds entry idx_r at rd_slot_r
        if (ram_rdata == val_r) begin
          pend_status_nxt = ST_OK;
          pend_data_nxt   = ram_rdata;
          pend_ram_nxt    = 1'b0;
          if (idx_plus < count_r) begin
            wr_slot_nxt = rd_slot_r;
            ram_re      = 1'b1;
            rd_slot_nxt = slot_inc;
            idx_nxt     = idx_plus;
            state_nxt   = S_SHIFT;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_EMIT;
          end
        end else if (idx_plus == count_r) begin
          pend_status_nxt = ST_NOTFOUND;
          pend_data_nxt   = '0;
          pend_ram_nxt    = 1'b0;
          state_nxt       = S_EMIT;
        end else begin
          ram_re      = 1'b1;
          rd_slot_nxt = slot_inc;
          idx_nxt     = idx_plus;
        end
      end

      S_SHIFT: begin
        // move entry idx_r one slot toward the front
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (idx_plus < count_r) begin
          wr_slot_nxt = rd_slot_r;
          ram_re      = 1'b1;
          rd_slot_nxt = slot_inc;
          idx_nxt     = idx_plus;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_EMIT;
        end
      end

      S_RDOUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = ram_rdata;
          out_last_nxt   = (idx_plus == count_r);
          if (idx_plus == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re      = 1'b1;
            rd_slot_nxt = slot_inc;
            idx_nxt     = idx_plus;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_data_nxt   = pend_ram_r ? ram_rdata : pend_data_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    val_r         <= val_nxt;
    idx_r         <= idx_nxt;
    rd_slot_r     <= rd_slot_nxt;
    wr_slot_r     <= wr_slot_nxt;
    pend_status_r <= pend_status_nxt;
    pend_data_r   <= pend_data_nxt;
    pend_ram_r    <= pend_ram_nxt;
    out_status_r  <= out_status_nxt;
    out_data_r    <= out_data_nxt;
    out_last_r    <= out_last_nxt;
  end

endmodule

`default_nettype wire

[hdl/bdq_ram.sv]
// ============================================================================
// bdq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
`default_nettype none

module bdq_ram
  import bdq_pkg::*;
#(
  parameter int WIDTH = WORD_W,
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the bounded ring deque. A queue of requests feeds
// a clocked driver; every accepted item is run through a local ring model
// whose expected results are compared field by field by a clocked monitor.
// Directed corner items come first, then random fill, drain and mixed bursts.
// ============================================================================

module testbench;
  import bdq_pkg::*;

  localparam int RING_DEPTH = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 280;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = RING_DEPTH + 24;
  localparam int IDLE_PCT = 34;
  localparam int HOLDOFF_AT = 60;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int QUIET_FROM = 150;
  localparam int QUIET_TO = 200;

  // operation codes the block must ignore
  localparam op_t OP_UNUSED_6 = 3'd6;
  localparam op_t OP_UNUSED_7 = 3'd7;

  typedef struct {
    op_t   op;
    word_t value;
    bit    drain_first;
  } request_t;

  typedef struct {
    status_t status;
    word_t   data;
    logic    last;
  } deque_result_t;

  logic clk;
  logic rst_n;

  bdq_in_if  in_if ();
  bdq_out_if out_if ();

  bounded_deque_with_value_delete u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  request_t      request_q[$];
  deque_result_t due_results[$];
  word_t         value_pool[6];

  // local copy of the ring
  word_t ring_word[RING_DEPTH];
  int    ring_head;
  int    ring_count;

  int accepted_in;
  int errors;
  int stall_cycles;
  int hold_left;
  bit hold_done;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic bit quiet_window();
    return accepted_in >= QUIET_FROM && accepted_in < QUIET_TO;
  endfunction

  task automatic expect_result(status_t st, word_t d, logic lst);
    deque_result_t r;
    r.status = st;
    r.data = d;
    r.last = lst;
    due_results.push_back(r);
  endtask

  // Apply one accepted item to the local ring and queue what it must produce.
  task automatic deque_apply(op_t op, word_t val);
    int    pos;
    word_t w;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (ring_count >= RING_DEPTH) begin
          expect_result(ST_FULL, '0, 1'b1);
        end else begin
          if (op == OP_INS_FRONT) begin
            ring_head = (ring_head + RING_DEPTH - 1) % RING_DEPTH;
            ring_word[ring_head] = val;
          end else begin
            ring_word[(ring_head + ring_count) % RING_DEPTH] = val;
          end
          ring_count++;
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (ring_count == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          if (op == OP_DEL_FRONT) begin
            w = ring_word[ring_head];
            ring_head = (ring_head + 1) % RING_DEPTH;
          end else begin
            w = ring_word[(ring_head + ring_count - 1) % RING_DEPTH];
          end
          ring_count--;
          expect_result(ST_OK, w, 1'b1);
        end
      end
      OP_DEL_VALUE: begin
        if (ring_count == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < ring_count && ring_word[(ring_head + pos) % RING_DEPTH] !== val)
            pos++;
          if (pos == ring_count) begin
            expect_result(ST_NOTFOUND, '0, 1'b1);
          end else begin
            w = ring_word[(ring_head + pos) % RING_DEPTH];
            // close the gap toward the front
            for (int j = pos; j + 1 < ring_count; j++)
              ring_word[(ring_head + j) % RING_DEPTH] =
                ring_word[(ring_head + j + 1) % RING_DEPTH];
            ring_count--;
            expect_result(ST_OK, w, 1'b1);
          end
        end
      end
      OP_READ_ALL: begin
        if (ring_count == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int k = 0; k < ring_count; k++)
            expect_result(ST_OK, ring_word[(ring_head + k) % RING_DEPTH],
                          k + 1 == ring_count);
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_request(op_t op, word_t val, bit drain_first = 1'b0);
    request_t r;
    r.op = op;
    r.value = val;
    r.drain_first = drain_first;
    request_q.push_back(r);
  endtask

  // burst kinds: 0 mostly inserts, 1 mostly deletes, 2 balanced
  function automatic op_t pick_op(int kind);
    int r;
    int ins_pct;
    r = $urandom_range(99);
    ins_pct = (kind == 0) ? 75 : (kind == 1) ? 15 : 45;
    if (r < 2)
      return (r == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
    if (r < 2 + ins_pct)
      return $urandom_range(1) ? OP_INS_BACK : OP_INS_FRONT;
    if (r < 91) begin
      case ($urandom_range(3))
        0:       return OP_DEL_FRONT;
        1:       return OP_DEL_BACK;
        default: return OP_DEL_VALUE;
      endcase
    end
    return OP_READ_ALL;
  endfunction

  // pool values repeat, so value deletes find matches and duplicates
  function automatic word_t pick_value();
    if ($urandom_range(99) < 70)
      return value_pool[$urandom_range(5)];
    return word_t'($urandom);
  endfunction

  initial begin
    int    made;
    int    kind;
    int    burst;
    op_t   op;
    word_t val;

    in_if.valid = 1'b0;
    in_if.operation = OP_INS_FRONT;
    in_if.value = '0;
    out_if.ready = 1'b0;
    rst_n = 1'b0;
    ring_head = 0;
    ring_count = 0;
    accepted_in = 0;
    errors = 0;
    stall_cycles = 0;
    hold_left = 0;
    hold_done = 1'b0;

    foreach (value_pool[i])
      value_pool[i] = word_t'($urandom);
    value_pool[5] = value_pool[4];

    // directed: empty cases, ignored codes, extremes, gap closing, wrap
    add_request(OP_READ_ALL, '0);
    add_request(OP_DEL_FRONT, '0);
    add_request(OP_DEL_BACK, '0);
    add_request(OP_DEL_VALUE, 32'sd0);
    add_request(OP_UNUSED_6, '1);
    add_request(OP_UNUSED_7, '0);
    add_request(OP_INS_FRONT, 32'sh7FFF_FFFF);
    add_request(OP_INS_BACK, 32'sh8000_0000);
    add_request(OP_INS_FRONT, 32'sd0);
    add_request(OP_INS_BACK, -32'sd1);
    // sender waits here until every queued result has come back
    add_request(OP_READ_ALL, '0, 1'b1);
    add_request(OP_DEL_VALUE, 32'sd12345);
    add_request(OP_DEL_VALUE, 32'sh7FFF_FFFF);
    add_request(OP_READ_ALL, '0);
    add_request(OP_DEL_FRONT, '0);
    add_request(OP_DEL_BACK, '0);
    add_request(OP_DEL_VALUE, 32'sh8000_0000);
    add_request(OP_READ_ALL, '0);
    add_request(OP_DEL_VALUE, 32'sh8000_0000);

    made = 0;
    while (made < RANDOM_ITEMS) begin
      kind = $urandom_range(2);
      burst = (kind == 0) ? $urandom_range(14, 26) : $urandom_range(10, 22);
      for (int n = 0; n < burst && made < RANDOM_ITEMS; n++) begin
        op = pick_op(kind);
        val = pick_value();
        // sender waits for the block to go quiet now and then
        add_request(op, val, (n == 0) && ($urandom_range(3) == 0));
        if (op != OP_UNUSED_6 && op != OP_UNUSED_7)
          made++;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // sampled mid-cycle, after the driver's updates have settled
    while (request_q.size() != 0 || in_if.valid)
      @(negedge clk);
    while (due_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && due_results.size() == 0) begin
      $display("PASS bounded_deque_with_value_delete");
    end else begin
      $display("FAIL bounded_deque_with_value_delete");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    request_t nxt;
    bit       go;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        deque_apply(in_if.operation, in_if.value);
        accepted_in++;
      end
      if (in_if.valid && !in_if.ready) begin
        // item still offered, hold it
      end else begin
        go = request_q.size() != 0;
        if (go && request_q[0].drain_first && due_results.size() != 0)
          go = 1'b0;
        if (go && !quiet_window() && $urandom_range(99) < IDLE_PCT)
          go = 1'b0;
        if (go) begin
          nxt = request_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.operation <= nxt.op;
          in_if.value <= nxt.value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    deque_result_t exp_r;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected item status %0d data %h last %b", $realtime,
                   out_if.status, out_if.data, out_if.last);
          errors++;
        end else begin
          exp_r = due_results.pop_front();
          if (out_if.status !== exp_r.status) begin
            $display("%0t: status mismatch expected %0d actual %0d", $realtime,
                     exp_r.status, out_if.status);
            errors++;
          end
          if (out_if.data !== exp_r.data) begin
            $display("%0t: data mismatch expected %h actual %h", $realtime,
                     exp_r.data, out_if.data);
            errors++;
          end
          if (out_if.last !== exp_r.last) begin
            $display("%0t: last mismatch expected %b actual %b", $realtime,
                     exp_r.last, out_if.last);
            errors++;
          end
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (!hold_done && accepted_in >= HOLDOFF_AT) begin
        hold_done = 1'b1;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= quiet_window() || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("FAIL bounded_deque_with_value_delete");
        $finish;
      end
    end
  end

endmodule

[sim.f]
hdl/bdq_pkg.sv
hdl/bdq_in_if.sv
hdl/bdq_out_if.sv
hdl/bdq_ram.sv
hdl/bounded_deque_with_value_delete.sv
tb/testbench.sv
